@@ sv/dfm_pkg.sv @@
package dfm_pkg;

    // Window and pattern geometry
    localparam int WINDOW_DEPTH = 34;
    localparam int BOUNDARY_LEN = 34;
    localparam int CTYPE_LEN    = 26;
    localparam int HDR_END_LEN  = 4;

    // Offsets of each pattern inside the window (oldest cell is index 0)
    localparam int BND_OFS   = WINDOW_DEPTH - BOUNDARY_LEN;
    localparam int CTYPE_OFS = WINDOW_DEPTH - CTYPE_LEN;
    localparam int HDR_OFS   = WINDOW_DEPTH - HDR_END_LEN;

    localparam int HELD_W = $clog2(BOUNDARY_LEN + 1);

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] SOI_HI = 8'hFF;
    localparam logic [7:0] SOI_LO = 8'hD8;

    localparam logic [7:0] BND_PAT [BOUNDARY_LEN] = '{
        8'h2D, 8'h2D, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30,
        8'h30, 8'h30, 8'h30, 8'h39, 8'h38, 8'h37, 8'h36, 8'h35, 8'h34, 8'h33,
        8'h32, 8'h31, 8'h0D, 8'h0A
    };

    // "Content-Type: image/jpeg\r\n"
    localparam logic [7:0] CTYPE_PAT [CTYPE_LEN] = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D, 8'h54, 8'h79,
        8'h70, 8'h65, 8'h3A, 8'h20, 8'h69, 8'h6D, 8'h61, 8'h67, 8'h65, 8'h2F,
        8'h6A, 8'h70, 8'h65, 8'h67, 8'h0D, 8'h0A
    };

    localparam logic [7:0] HDR_PAT [HDR_END_LEN] = '{8'h0D, 8'h0A, 8'h0D, 8'h0A};

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_END     = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_JPEG = 2'd1,
        ST_SHORT    = 2'd2,
        ST_HDR_ERR  = 2'd3
    } status_t;

    // Per-cell pattern characters; care bits mark cells inside the pattern
    typedef struct packed {
        logic [7:0] bnd_char;
        logic       bnd_care;
        logic [7:0] ctype_char;
        logic       ctype_care;
        logic [7:0] hdr_char;
        logic       hdr_care;
    } cell_pat_t;

    typedef struct packed {
        logic bnd;
        logic ctype;
        logic hdr;
    } cell_hit_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       first;
        status_t    status;
    } res_t;

    typedef struct packed {
        logic [1:0] cnt;
        res_t       res_a;
        res_t       res_b;
    } fifo_push_t;

    typedef struct packed {
        logic valid;
        logic room;
        res_t head;
    } fifo_stat_t;

endpackage

@@ sv/dfm_cell.sv @@
module dfm_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  logic              clr,
    input  logic [7:0]        d_in,
    input  dfm_pkg::cell_pat_t pat,
    output logic [7:0]        q,
    output dfm_pkg::cell_hit_t hit
);
    import dfm_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Take the neighbor's byte on a shift, zero on a drop
    always_comb
    begin
        byte_next = byte_reg;
        if (clr)
        begin
            byte_next = 8'h00;
        end
        else if (shift)
        begin
            byte_next = d_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'h00;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    // Compare the incoming byte against this position's pattern chars
    assign hit.bnd   = !pat.bnd_care   || (d_in == pat.bnd_char);
    assign hit.ctype = !pat.ctype_care || (d_in == pat.ctype_char);
    assign hit.hdr   = !pat.hdr_care   || (d_in == pat.hdr_char);

    assign q = byte_reg;

endmodule

@@ sv/dfm_fifo.sv @@
module dfm_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  dfm_pkg::fifo_push_t push,
    input  logic               pop,
    output dfm_pkg::fifo_stat_t stat
);
    import dfm_pkg::*;

    res_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_b;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic [FIFO_CNT_W-1:0] cnt_next;
    logic                  do_pop;

    assign do_pop   = pop && (cnt_reg != '0);
    assign wr_ptr_b = wr_ptr_reg + FIFO_PTR_W'(1);

    // Advance pointers and occupancy
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(do_pop);
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.cnt);
        cnt_next    = cnt_reg + FIFO_CNT_W'(push.cnt) - FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store up to two results per cycle
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.res_a;
        end
        if (push.cnt == 2'd2)
        begin
            mem_reg[wr_ptr_b] <= push.res_b;
        end
    end

    assign stat.valid = (cnt_reg != '0);
    assign stat.room  = (cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign stat.head  = mem_reg[rd_ptr_reg];

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue over capacity");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd0) |-> (cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
        else $error("push into result queue without room");

    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd0 && !do_pop) |=> $stable(cnt_reg))
        else $error("queue occupancy moved without push or pop");
`endif

endmodule

@@ sv/mjpeg_multipart_deframer.sv @@
// Multipart MJPEG stream deframer.
// Input channel: one byte of the HTTP response body per request
// (stream_byte, in_valid, in_stall). Output channel: one result per
// request (item_kind, payload_byte, first_of_frame, frame_status,
// out_valid, out_stall). A result is either a payload byte or a frame end
// carrying the frame status.
// Payload bytes travel through a 34-cell shift chain and leave it 34
// accepted bytes later, so the part boundary is never emitted. Results
// are registered in the result queue before they reach the output.
// Throughput is one input byte per cycle while in_stall is low; the
// chain compares all pattern positions in parallel each cycle. A byte
// can cause two results (last payload byte plus frame end); a four-entry
// result queue absorbs this and in_stall rises while fewer than two queue
// entries are free. When the receiver stalls, the queue fills and in_stall
// follows. Reset clears the chain to zero, empties the queue and puts the
// parser in the seeking state; no clearing pass is needed.
module mjpeg_multipart_deframer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] stream_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       item_kind,
    output logic [7:0] payload_byte,
    output logic       first_of_frame,
    output logic [1:0] frame_status
);
    import dfm_pkg::*;

    typedef enum logic [2:0] {
        MODE_SEEK = 3'b001,
        MODE_HDR  = 3'b010,
        MODE_PAY  = 3'b100
    } mode_t;

    mode_t             mode_reg;
    mode_t             mode_next;
    logic [HELD_W-1:0] held_reg;
    logic [HELD_W-1:0] held_next;
    logic [1:0]        seen_reg;
    logic [1:0]        seen_next;
    logic              soi_reg;
    logic              soi_next;

    logic              accept;
    logic              clr;
    logic              emit;
    logic [7:0]        leaving;
    logic              bnd_hit;
    logic              ctype_hit;
    logic              hdr_hit;
    res_t              pay_res;
    res_t              end_res;
    logic              end_valid;
    fifo_push_t        push;
    fifo_stat_t        fstat;

    logic [7:0]        chain_d [WINDOW_DEPTH];
    logic [7:0]        chain_q [WINDOW_DEPTH];
    cell_hit_t         hits    [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] bnd_vec;
    logic [WINDOW_DEPTH-1:0] ctype_vec;
    logic [WINDOW_DEPTH-1:0] hdr_vec;

    assign accept = in_valid && !in_stall;
    assign in_stall = !fstat.room;

    // Build the shift chain, newest byte enters the top cell
    for (genvar k = 0; k < WINDOW_DEPTH; k++)
    begin : g_cell
        cell_pat_t pat;

        if (k == WINDOW_DEPTH - 1)
        begin : g_top
            assign chain_d[k] = stream_byte;
        end
        else
        begin : g_mid
            assign chain_d[k] = chain_q[k + 1];
        end

        if (k >= BND_OFS)
        begin : g_bnd
            assign pat.bnd_char = BND_PAT[k - BND_OFS];
            assign pat.bnd_care = 1'b1;
        end
        else
        begin : g_nobnd
            assign pat.bnd_char = 8'h00;
            assign pat.bnd_care = 1'b0;
        end

        if (k >= CTYPE_OFS)
        begin : g_ct
            assign pat.ctype_char = CTYPE_PAT[k - CTYPE_OFS];
            assign pat.ctype_care = 1'b1;
        end
        else
        begin : g_noct
            assign pat.ctype_char = 8'h00;
            assign pat.ctype_care = 1'b0;
        end

        if (k >= HDR_OFS)
        begin : g_hdr
            assign pat.hdr_char = HDR_PAT[k - HDR_OFS];
            assign pat.hdr_care = 1'b1;
        end
        else
        begin : g_nohdr
            assign pat.hdr_char = 8'h00;
            assign pat.hdr_care = 1'b0;
        end

        dfm_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (accept),
            .clr   (clr),
            .d_in  (chain_d[k]),
            .pat   (pat),
            .q     (chain_q[k]),
            .hit   (hits[k])
        );

        assign bnd_vec[k]   = hits[k].bnd;
        assign ctype_vec[k] = hits[k].ctype;
        assign hdr_vec[k]   = hits[k].hdr;
    end

    assign bnd_hit   = &bnd_vec;
    assign ctype_hit = &ctype_vec;
    assign hdr_hit   = &hdr_vec;
    assign leaving   = chain_q[BND_OFS];

    assign emit = (mode_reg == MODE_PAY) && (held_reg >= HELD_W'(BOUNDARY_LEN));

    // Parser control and start-of-image tracking
    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        seen_next = seen_reg;
        soi_next  = soi_reg;
        clr       = 1'b0;
        end_valid = 1'b0;
        end_res   = '{kind: KIND_END, data: 8'h00, first: 1'b0, status: ST_OK};

        if (mode_reg == MODE_PAY)
        begin
            held_next = emit ? HELD_W'(BOUNDARY_LEN) : held_reg + HELD_W'(1);
        end

        if (emit)
        begin
            if (seen_reg == 2'd0)
            begin
                soi_next = (leaving == SOI_HI);
            end
            else if (seen_reg == 2'd1)
            begin
                soi_next = soi_reg && (leaving == SOI_LO);
            end
            if (seen_reg < 2'd2)
            begin
                seen_next = seen_reg + 2'd1;
            end
        end

        priority if (bnd_hit)
        begin
            // Boundary: close the frame in payload mode or flag the header in header mode, then drop all
            if (mode_reg == MODE_PAY)
            begin
                end_valid = 1'b1;
                if (seen_next < 2'd2)
                begin
                    end_res.status = ST_SHORT;
                end
                else
                begin
                    end_res.status = soi_next ? ST_OK : ST_NOT_JPEG;
                end
            end
            else if (mode_reg == MODE_HDR)
            begin
                end_valid      = 1'b1;
                end_res.status = ST_HDR_ERR;
            end
            clr       = accept;
            held_next = '0;
            mode_next = MODE_SEEK;
        end
        else if (mode_reg == MODE_HDR)
        begin
            if (hdr_hit)
            begin
                mode_next = MODE_PAY;
                held_next = '0;
                seen_next = 2'd0;
                soi_next  = 1'b0;
            end
        end
        else if (mode_reg != MODE_PAY)
        begin
            mode_next = ctype_hit ? MODE_HDR : MODE_SEEK;
        end
        else
        begin
            mode_next = MODE_PAY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SEEK;
            held_reg <= '0;
            seen_reg <= 2'd0;
            soi_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            seen_reg <= seen_next;
            soi_reg  <= soi_next;
        end
    end

    // Order results: payload byte first, then frame end
    always_comb
    begin
        pay_res = '{kind: KIND_PAYLOAD, data: leaving, first: (seen_reg == 2'd0),
                    status: ST_OK};
        push.res_b = end_res;
        if (!accept)
        begin
            push.cnt   = 2'd0;
            push.res_a = pay_res;
        end
        else
        begin
            unique case ({emit, end_valid})
                2'b11:
                begin
                    push.cnt   = 2'd2;
                    push.res_a = pay_res;
                end
                2'b10:
                begin
                    push.cnt   = 2'd1;
                    push.res_a = pay_res;
                end
                2'b01:
                begin
                    push.cnt   = 2'd1;
                    push.res_a = end_res;
                end
                default:
                begin
                    push.cnt   = 2'd0;
                    push.res_a = pay_res;
                end
            endcase
        end
    end

    dfm_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (!out_stall),
        .stat  (fstat)
    );

    assign out_valid      = fstat.valid;
    assign item_kind      = fstat.head.kind;
    assign payload_byte   = fstat.head.data;
    assign first_of_frame = fstat.head.first;
    assign frame_status   = fstat.head.status;

`ifndef SYNTH
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HELD_W'(BOUNDARY_LEN))
        else $error("held count beyond window");

    a_emit_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd0 && push.res_a.kind == KIND_PAYLOAD) |-> (mode_reg == MODE_PAY))
        else $error("payload byte released outside payload mode");

    a_end_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_valid) |=> (mode_reg == MODE_SEEK && held_reg == '0))
        else $error("frame end did not return parser to seeking");
`endif

endmodule
